// ===== rtl/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, register indexes and types for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 24;
   localparam int N_TAPS  = 9;
   localparam int N_LANES = 3;

   // A 3x3 sum of 8-bit values stays below 2296. Multiplying by
   // ceil(2^16 / 9) and keeping bits above 16 gives the exact floor of the
   // sum over nine across that range.
   localparam int SUM_W      = 12;
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int DIV9_SHIFT = 16;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

   localparam int FRAME_WIDTH_W = 12;
   localparam int HEIGHT_W      = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam int RESET_WIDTH = 640;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [N_TAPS-1:0][CHAN_W-1:0] taps_type;
   typedef logic [N_LANES-1:0][CHAN_W-1:0] chans_type;

   typedef struct packed {
      logic valid;
      logic pixel;
      logic emit;
      logic interior;
      logic frame_end;
      logic from_window;
   } item_flags_type;

endpackage

// ===== rtl/bbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Box blur control
// Frame size registers, input and output raster positions, pending count and
// the flush state; classifies every accepted item.
// ----------------------------------------------------------------------------
module bbr_ctrl #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                accept,
   input  logic                                drain,
   output bbr_pkg::item_flags_type             flags,
   output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int XW   = WW + 1;
   localparam int HW   = bbr_pkg::HEIGHT_W;
   localparam int RW   = HW + 1;
   localparam int FW   = bbr_pkg::FRAME_WIDTH_W;
   localparam int CMPW = WW + FW;
   localparam int ResetWidth =
      (bbr_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bbr_pkg::RESET_WIDTH;

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff, col_in, ocol_ff, ocol_in;
   logic [HW-1:0] row_ff, row_in, orow_ff, orow_in;
   logic [XW-1:0] pend_ff, pend_in;
   logic          flush_ff, flush_in;

   logic [FW-1:0] wr_width;
   logic [XW-1:0] w_x, col_x, ocol_x;
   logic [RW-1:0] h_x, row_x, orow_x;
   logic          col_last, row_last, ocol_last, orow_last;
   logic          pix_emit, drn_emit, full, border;

   always_comb begin
      wr_width  = csr_wdata[FW-1:0];
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            bbr_pkg::CSR_FRAME_WIDTH: begin
               if (wr_width == '0) begin
                  width_in = WW'(1);
               end else if (CMPW'(wr_width) > CMPW'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(wr_width);
               end
            end
            bbr_pkg::CSR_FRAME_HEIGHT: begin
               height_in = (csr_wdata == '0) ? HW'(1) : HW'(csr_wdata);
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_comb begin
      w_x    = XW'(width_ff);
      col_x  = XW'(col_ff);
      ocol_x = XW'(ocol_ff);
      h_x    = RW'(height_ff);
      row_x  = RW'(row_ff);
      orow_x = RW'(orow_ff);

      col_last  = (col_x + XW'(1)) >= w_x;
      row_last  = (row_x + RW'(1)) >= h_x;
      ocol_last = (ocol_x + XW'(1)) >= w_x;
      orow_last = (orow_x + RW'(1)) >= h_x;

      pix_emit = pend_ff > w_x;
      full     = pend_ff == (w_x + XW'(1));
      drn_emit = flush_ff && (pend_ff != '0);
      border   = (orow_ff == '0) || ((orow_x + RW'(2)) > h_x) ||
                 (ocol_ff == '0) || ((ocol_x + XW'(2)) > w_x);

      flags.valid       = accept;
      flags.pixel       = !drain;
      flags.emit        = drain ? drn_emit : pix_emit;
      flags.interior    = !drain && pix_emit && !border;
      flags.frame_end   = ((orow_x + RW'(1)) == h_x) && ((ocol_x + XW'(1)) == w_x);
      flags.from_window = drain && full;

      rd_addr = drain ? ocol_ff : col_ff;
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      pend_in  = pend_ff;
      flush_in = flush_ff;
      if (accept) begin
         if (drain) begin
            if (drn_emit) begin
               if (ocol_last) begin
                  ocol_in = '0;
                  orow_in = orow_last ? '0 : orow_ff + HW'(1);
               end else begin
                  ocol_in = ocol_ff + CW'(1);
               end
               pend_in = pend_ff - XW'(1);
               if (pend_ff == XW'(1)) begin
                  flush_in = 1'b0;
               end
            end else if (pend_ff == '0) begin
               flush_in = 1'b0;
            end
         end else begin
            flush_in = col_last && row_last;
            if (col_last) begin
               col_in = '0;
               row_in = row_last ? '0 : row_ff + HW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
            if (pix_emit) begin
               if (ocol_last) begin
                  ocol_in = '0;
                  orow_in = orow_last ? '0 : orow_ff + HW'(1);
               end else begin
                  ocol_in = ocol_ff + CW'(1);
               end
            end else begin
               pend_in = pend_ff + XW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(ResetWidth);
         height_ff <= bbr_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         pend_ff   <= '0;
         flush_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         pend_ff   <= pend_in;
         flush_ff  <= flush_in;
      end
   end

endmodule

// ===== rtl/bbr_line_buf.sv =====
// ----------------------------------------------------------------------------
// Box blur line buffer
// Two row memories indexed by column: the upper one holds the previous row,
// the lower one the row before that, filled from the upper one's read data.
// ----------------------------------------------------------------------------
module bbr_line_buf #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
   input  bbr_pkg::pixel_type            wr_pixel,
   input  logic                          cascade_en,
   output bbr_pkg::pixel_type            above1,
   output bbr_pkg::pixel_type            above2
);

   localparam int CW = $clog2(MAX_WIDTH);

   bbr_pkg::pixel_type row1_mem [MAX_WIDTH];
   bbr_pkg::pixel_type row2_mem [MAX_WIDTH];
   bbr_pkg::pixel_type above1_ff, above2_ff;
   logic [CW-1:0]      addr_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         above1_ff <= row1_mem[addr];
         addr_ff   <= addr;
      end
      if (wr_en) begin
         row1_mem[addr] <= wr_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         above2_ff <= row2_mem[addr];
      end
      if (cascade_en) begin
         row2_mem[addr_ff] <= above1_ff;
      end
   end

   assign above1 = above1_ff;
   assign above2 = above2_ff;

endmodule

// ===== rtl/bbr_lane.sv =====
// ----------------------------------------------------------------------------
// Box blur lane
// Sums the nine window values of one colour channel, then divides by nine
// with a reciprocal multiply. Two register stages.
// ----------------------------------------------------------------------------
module bbr_lane (
   input  logic                          clock,
   input  logic                          step,
   input  bbr_pkg::taps_type             taps,
   output logic [bbr_pkg::CHAN_W-1:0]    mean
);

   localparam int SW = bbr_pkg::SUM_W;
   localparam int PW = bbr_pkg::PROD_W;

   logic [SW-1:0] top_sum, mid_sum, bot_sum, sum_in, sum_ff;
   logic [PW-1:0] prod;
   logic [bbr_pkg::CHAN_W-1:0] mean_ff;

   always_comb begin
      top_sum = SW'(taps[0]) + SW'(taps[1]) + SW'(taps[2]);
      mid_sum = SW'(taps[3]) + SW'(taps[4]) + SW'(taps[5]);
      bot_sum = SW'(taps[6]) + SW'(taps[7]) + SW'(taps[8]);
      sum_in  = top_sum + mid_sum + bot_sum;
      prod    = PW'(sum_ff) * PW'(bbr_pkg::DIV9_RECIP);
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sum_ff  <= sum_in;
         mean_ff <= prod[bbr_pkg::DIV9_SHIFT +: bbr_pkg::CHAN_W];
      end
   end

   assign mean = mean_ff;

endmodule

// ===== rtl/bbr_merge.sv =====
// ----------------------------------------------------------------------------
// Box blur merge and output register
// Joins the three lane means, or the unfiltered pixel on the border, into
// one result item and holds it until the consumer takes it.
// ----------------------------------------------------------------------------
module bbr_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  bbr_pkg::item_flags_type       flags,
   input  bbr_pkg::chans_type            means,
   input  bbr_pkg::pixel_type            pass,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [bbr_pkg::CHAN_W-1:0]    rsp_blue_out,
   output logic [bbr_pkg::CHAN_W-1:0]    rsp_green_out,
   output logic [bbr_pkg::CHAN_W-1:0]    rsp_red_out,
   output logic                          rsp_frame_end,
   output logic                          hold
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic               load;
   bbr_pkg::pixel_type pix_ff, pix_in;
   logic               end_ff;

   always_comb begin
      hold         = flags.valid && flags.emit && rsp_valid_ff && !rsp_ready;
      load         = flags.valid && flags.emit && !hold;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      pix_in       = flags.interior ? bbr_pkg::pixel_type'(means) : pass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= pix_in;
         end_ff <= flags.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = pix_ff[0 +: bbr_pkg::CHAN_W];
   assign rsp_green_out = pix_ff[bbr_pkg::CHAN_W +: bbr_pkg::CHAN_W];
   assign rsp_red_out   = pix_ff[2*bbr_pkg::CHAN_W +: bbr_pkg::CHAN_W];
   assign rsp_frame_end = end_ff;

endmodule

// ===== rtl/box_blur_3x3_rgb_top.sv =====
// ----------------------------------------------------------------------------
// 3x3 RGB box blur
// Raster-order pixel stream in, blurred stream out, border pixels unchanged.
//
//   Channel   Handshake            Payload
//   req       req_valid/req_ready  blue, green, red, drain
//   rsp       rsp_valid/rsp_ready  blue, green, red, frame_end
//   csr       csr_we               csr_index, csr_wdata
//
// One item is taken every cycle while the input is not held off. A result
// reaches the output register through line memory read, window shift,
// lane sum, reciprocal multiply and merge. Reset is synchronous; the line
// memories need no clearing. Input is held off only while a result waits
// in the output register and the next result has reached the last stage.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bbr_pkg::CHAN_W-1:0]        req_blue_in,
   input  logic [bbr_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [bbr_pkg::CHAN_W-1:0]        req_red_in,
   input  logic                              req_drain,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bbr_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic [bbr_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [bbr_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic                              rsp_frame_end,
   input  logic                              csr_we,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int PX = bbr_pkg::PIX_W;
   localparam int CH = bbr_pkg::CHAN_W;

   bbr_pkg::item_flags_type flags0, s1_ff, s2_ff, s3_ff, s4_ff;
   logic                    adv, hold, accept;
   logic [CW-1:0]           rd_addr;
   bbr_pkg::pixel_type      px1_ff, above1, above2, drn2_ff;
   bbr_pkg::pixel_type      pass_in, pass3_ff, pass4_ff;
   logic [8:0][PX-1:0]      win_ff;
   bbr_pkg::chans_type      means;

   assign adv       = !hold;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   bbr_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .drain     (req_drain),
      .flags     (flags0),
      .rd_addr   (rd_addr)
   );

   bbr_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock      (clock),
      .rd_en      (accept),
      .wr_en      (accept && !req_drain),
      .addr       (rd_addr),
      .wr_pixel   ({req_red_in, req_green_in, req_blue_in}),
      .cascade_en (adv && s1_ff.valid && s1_ff.pixel),
      .above1     (above1),
      .above2     (above2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else if (adv) begin
         s1_ff <= flags0;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
      end
   end

   // Window rows run oldest to newest; the right-hand column takes the two
   // line memory outputs and the incoming pixel.
   always_comb begin
      if (s2_ff.pixel) begin
         pass_in = win_ff[4];
      end else if (s2_ff.from_window) begin
         pass_in = win_ff[5];
      end else begin
         pass_in = drn2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff <= {req_red_in, req_green_in, req_blue_in};
      end
      if (adv) begin
         if (s1_ff.valid && s1_ff.pixel) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= above2;
            win_ff[3] <= win_ff[4];
            win_ff[4] <= win_ff[5];
            win_ff[5] <= above1;
            win_ff[6] <= win_ff[7];
            win_ff[7] <= win_ff[8];
            win_ff[8] <= px1_ff;
         end
         drn2_ff  <= above1;
         pass3_ff <= pass_in;
         pass4_ff <= pass3_ff;
      end
   end

   for (genvar l = 0; l < bbr_pkg::N_LANES; l++) begin : g_lane
      bbr_pkg::taps_type taps;

      for (genvar k = 0; k < bbr_pkg::N_TAPS; k++) begin : g_tap
         assign taps[k] = win_ff[k][l*CH +: CH];
      end

      bbr_lane u_lane (
         .clock (clock),
         .step  (adv),
         .taps  (taps),
         .mean  (means[l])
      );
   end

   bbr_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .flags         (s4_ff),
      .means         (means),
      .pass          (pass4_ff),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_frame_end (rsp_frame_end),
      .hold          (hold)
   );

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (s4_ff.valid && s4_ff.emit && !hold) |=> rsp_valid)
      else $error("Result at the last stage did not reach the output register.");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s4_ff.valid && s4_ff.emit))
      else $error("Output became valid without an emitting item.");

   a_interior_source: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.interior) |-> (s1_ff.pixel && s1_ff.emit && !s1_ff.from_window))
      else $error("Filtered result marked for an item that is not an emitting pixel.");

endmodule

// ===== tb/box_blur_checker.sv =====
// ----------------------------------------------------------------------------
// Box blur checker
// Watches the pixel, result and register ports of the 3x3 RGB box blur. It
// keeps its own line history, raster positions and frame size, works out the
// blurred pixel that each accepted item releases, and compares every accepted
// result field by field with the oldest blurred pixel still due.
// ----------------------------------------------------------------------------
module box_blur_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [bbr_pkg::CHAN_W-1:0]        req_blue_in,
   input  logic [bbr_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [bbr_pkg::CHAN_W-1:0]        req_red_in,
   input  logic                              req_drain,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [bbr_pkg::CHAN_W-1:0]        rsp_blue_out,
   input  logic [bbr_pkg::CHAN_W-1:0]        rsp_green_out,
   input  logic [bbr_pkg::CHAN_W-1:0]        rsp_red_out,
   input  logic                              rsp_frame_end,
   input  logic                              csr_we,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                error_count,
   output int                                awaited
);

   localparam int unsigned HIST_DEPTH = 2 * MAX_WIDTH + 4;

   typedef struct packed {
      logic [bbr_pkg::CHAN_W-1:0] blue;
      logic [bbr_pkg::CHAN_W-1:0] green;
      logic [bbr_pkg::CHAN_W-1:0] red;
      logic                       frame_end;
   } blurred_pixel_type;

   bbr_pkg::pixel_type history [HIST_DEPTH];
   logic [bbr_pkg::FRAME_WIDTH_W-1:0] width_reg;
   logic [bbr_pkg::HEIGHT_W-1:0]      height_reg;
   int unsigned in_col, in_row, out_col, out_row, backlog, wr_ptr;
   bit flushing;
   blurred_pixel_type blurred_due [$];

   function automatic int unsigned width_now();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int unsigned height_now();
      return (height_reg == 0) ? 1 : int'(height_reg);
   endfunction

   task automatic step_position(inout int unsigned col, inout int unsigned row,
                                input int unsigned w, input int unsigned h);
      if (col + 1 >= w) begin
         col = 0;
         row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col = col + 1;
      end
   endtask

   // The oldest stored pixel leaves: blurred if it lies inside the border,
   // unchanged otherwise.
   task automatic blur_oldest();
      int unsigned w, h, base, idx, sum, ch, dr, dc;
      bbr_pkg::pixel_type blurred;
      blurred_pixel_type due;
      w = width_now();
      h = height_now();
      base = (wr_ptr + HIST_DEPTH - (backlog % HIST_DEPTH)) % HIST_DEPTH;
      blurred = history[base];
      if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
         for (ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (dr = 0; dr < 3; dr++) begin
               for (dc = 0; dc < 3; dc++) begin
                  idx = (base + 2 * HIST_DEPTH + dr * w + dc - w - 1) % HIST_DEPTH;
                  sum += history[idx][8*ch +: 8];
               end
            end
            blurred[8*ch +: 8] = 8'(sum / 9);
         end
      end
      due.blue = blurred[7:0];
      due.green = blurred[15:8];
      due.red = blurred[23:16];
      due.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
      blurred_due.push_back(due);
      step_position(out_col, out_row, w, h);
      backlog--;
   endtask

   task automatic absorb_item(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red, input logic drain);
      int unsigned w, h;
      w = width_now();
      h = height_now();
      if (drain) begin
         if (flushing && backlog > 0) begin
            blur_oldest();
            if (backlog == 0) flushing = 1'b0;
         end else if (backlog == 0) begin
            flushing = 1'b0;
         end
      end else begin
         flushing = 1'b0;
         history[wr_ptr] = {red, green, blue};
         wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
         if (backlog < HIST_DEPTH - 1) backlog++;
         if (in_row + 1 >= h && in_col + 1 >= w) flushing = 1'b1;
         step_position(in_col, in_row, w, h);
         if (backlog > w + 1) blur_oldest();
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_blurred();
      blurred_pixel_type want;
      if (blurred_due.size() == 0) begin
         $display("%0t: unexpected item: expected none actual %0d/%0d/%0d end %0b",
                  $time, rsp_blue_out, rsp_green_out, rsp_red_out, rsp_frame_end);
         error_count++;
      end else begin
         want = blurred_due.pop_front();
         compare_field("blue", want.blue, rsp_blue_out);
         compare_field("green", want.green, rsp_green_out);
         compare_field("red", want.red, rsp_red_out);
         compare_field("frame_end", {7'b0, want.frame_end}, {7'b0, rsp_frame_end});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = bbr_pkg::FRAME_WIDTH_W'(bbr_pkg::RESET_WIDTH);
         height_reg = bbr_pkg::RESET_HEIGHT;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         backlog = 0;
         wr_ptr = 0;
         flushing = 1'b0;
         blurred_due.delete();
         error_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == bbr_pkg::CSR_FRAME_WIDTH) begin
               width_reg = csr_wdata[bbr_pkg::FRAME_WIDTH_W-1:0];
            end else if (csr_index == bbr_pkg::CSR_FRAME_HEIGHT) begin
               height_reg = csr_wdata[bbr_pkg::HEIGHT_W-1:0];
            end
         end
         if (req_valid && req_ready) begin
            absorb_item(req_blue_in, req_green_in, req_red_in, req_drain);
         end
         if (rsp_valid && rsp_ready) check_blurred();
      end
      awaited = blurred_due.size();
   end

endmodule

// ===== tb/box_blur_3x3_rgb_top_tb.sv =====
// ----------------------------------------------------------------------------
// Box blur testbench
// Drives pixel frames of many sizes through the 3x3 RGB box blur with random
// gaps on both channels, flush sequences complete and cut short, stray drain
// items and one long stall of the result side. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top_tb;

   localparam int MAX_W = 2048;
   localparam int WIDE_W = 40;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_AFTER = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_PIXELS = 24;
   localparam int N_SHAPES = 10;
   localparam int TIME_LIMIT = 10_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [bbr_pkg::CHAN_W-1:0] req_blue_in = '0;
   logic [bbr_pkg::CHAN_W-1:0] req_green_in = '0;
   logic [bbr_pkg::CHAN_W-1:0] req_red_in = '0;
   logic req_drain = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [bbr_pkg::CHAN_W-1:0] rsp_blue_out;
   logic [bbr_pkg::CHAN_W-1:0] rsp_green_out;
   logic [bbr_pkg::CHAN_W-1:0] rsp_red_out;
   logic rsp_frame_end;
   logic csr_we = 1'b0;
   logic [bbr_pkg::CSR_INDEX_W-1:0] csr_index = bbr_pkg::CSR_FRAME_WIDTH;
   logic [bbr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int error_count;
   int awaited;
   bit send_steady = 1'b0;

   // A width or height of zero below stands for a size drawn at random.
   int unsigned shape_width [N_SHAPES] = '{1, 1, 2, 3, 4, 6, 5, 8, 0, 0};
   int unsigned shape_height [N_SHAPES] = '{1, 4, 2, 3, 5, 3, 1, 6, 0, 0};

   box_blur_3x3_rgb_top #(.MAX_WIDTH(MAX_W)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in),
      .req_red_in(req_red_in), .req_drain(req_drain),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blue_out(rsp_blue_out), .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out), .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   box_blur_checker #(.MAX_WIDTH(MAX_W)) checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in),
      .req_red_in(req_red_in), .req_drain(req_drain),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blue_out(rsp_blue_out), .rsp_green_out(rsp_green_out),
      .rsp_red_out(rsp_red_out), .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .awaited(awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap(inout bit steady);
      if ($urandom_range(0, 24) == 0) steady = !steady;
      return steady ? 0 : int'($urandom_range(0, 12));
   endfunction

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic offer_item(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red, input logic drain);
      int gap;
      gap = draw_gap(send_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_blue_in <= blue;
      req_green_in <= green;
      req_red_in <= red;
      req_drain <= drain;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic offer_drain();
      offer_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic program_frame(input int unsigned w, input int unsigned h);
      csr_we <= 1'b1;
      csr_index <= bbr_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= bbr_pkg::CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= bbr_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= bbr_pkg::CSR_DATA_W'(h);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (awaited == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One frame with stray drain items, then a full or a cut-short flush.
   task automatic send_frame(input int unsigned w, input int unsigned h);
      int unsigned n;
      for (n = 0; n < w * h; n++) begin
         if ($urandom_range(0, 15) == 0) offer_drain();
         offer_item(random_channel(), random_channel(), random_channel(), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(0, w)) offer_drain();
      end else begin
         repeat (w + 1) offer_drain();
      end
   endtask

   initial begin : stimulus
      int unsigned p, n, w, h, sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frame with an interior pixel: saturated blue, a green sum
      // that floors to zero and an alternating red pattern.
      program_frame(3, 3);
      offer_drain();
      for (n = 0; n < 9; n++) begin
         offer_item(8'hFF, (n == 4) ? 8'd8 : 8'd0, n[0] ? 8'hAA : 8'h55, 1'b0);
      end
      repeat (5) offer_drain();
      settle();

      program_frame(1, 1);
      offer_item(8'h00, 8'h00, 8'h00, 1'b0);
      offer_drain();
      offer_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
      offer_drain();
      settle();

      for (p = 0; p < N_SHAPES; p++) begin
         w = (shape_width[p] == 0) ? $urandom_range(1, 12) : shape_width[p];
         h = (shape_height[p] == 0) ? $urandom_range(1, 9) : shape_height[p];
         program_frame(w, h);
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            send_frame(w, h);
            sent += w * h;
         end
         repeat (w + 1) offer_drain();
         settle();
      end

      // Wide rows in the tallest frame: the frame is left unfinished.
      program_frame(WIDE_W, 16'hFFFF);
      for (n = 0; n < 2 * WIDE_W + 30; n++) begin
         if ($urandom_range(0, 31) == 0) offer_drain();
         offer_item(random_channel(), random_channel(), random_channel(), 1'b0);
      end
      settle();

      if (error_count == 0 && awaited == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : result_sink
      int gap;
      int taken;
      bit steady;
      taken = 0;
      steady = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = (taken == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(steady);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : watchdog
      #(TIME_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== box_blur_3x3_rgb_top.f =====
rtl/bbr_pkg.sv
rtl/bbr_ctrl.sv
rtl/bbr_line_buf.sv
rtl/bbr_lane.sv
rtl/bbr_merge.sv
rtl/box_blur_3x3_rgb_top.sv
tb/box_blur_checker.sv
tb/box_blur_3x3_rgb_top_tb.sv
